>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL: concurrent checks on clk_i, with and without reset gating.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check on every clk_i edge outside reset
`define ILIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// check on every clk_i edge, reset included
`define ILIS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ILIS_ASSERT(lbl, prop, msg)
`define ILIS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/ilis_pkg.sv
// Package: widths and controller/datapath interface types for the span interpolator.
package ilis_pkg;

  localparam int unsigned StepW    = 6;
  localparam int unsigned RiseW    = 15;
  localparam int unsigned ValW     = 16;
  localparam int unsigned ErrW     = 9;
  localparam int unsigned DivIters = RiseW;
  localparam int unsigned DivCntW  = $clog2(DivIters);

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic init_err;
    logic emit;
  } ilis_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic steps_zero;
    logic at_last;
  } ilis_stat_t;

endpackage

>>> rtl/ilis_ctrl.sv
// Controller: sequences load, bit-serial divide, error init and sample emission.
module ilis_ctrl import ilis_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  ilis_stat_t stat_i,
  output ilis_cmd_t  cmd_o,
  output logic       busy_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StInit = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    cmd_o     = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          div_cnt_d  = '0;
          state_d    = stat_i.steps_zero ? StEmit : StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + 1'b1;
        if (div_cnt_q == DivCntW'(DivIters - 1)) begin
          state_d = StInit;
        end
      end
      StInit: begin
        cmd_o.init_err = 1'b1;
        state_d        = StEmit;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        if (stat_i.at_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

endmodule

>>> rtl/ilis_dp.sv
// Datapath: restoring divider, error term and sample accumulator.
module ilis_dp import ilis_pkg::*; (
  input  logic                   clk_i,
  input  ilis_cmd_t              cmd_i,
  input  logic [StepW-1:0]       span_steps_i,
  input  logic [RiseW-1:0]       rise_i,
  input  logic signed [ValW-1:0] start_value_i,
  output ilis_stat_t             stat_o,
  output logic signed [ValW-1:0] sample_o,
  output logic                   last_o
);

  logic [StepW-1:0]       steps_q;
  logic [StepW-1:0]       rem_q;
  logic [RiseW-1:0]       quo_q;
  logic [ValW-1:0]        val_q;
  logic signed [ErrW-1:0] err_q;
  logic [StepW-1:0]       cnt_q;

  logic [StepW:0]         part;
  logic [StepW+1:0]       diff;
  logic                   fits;
  logic signed [ErrW-1:0] inc_small;
  logic signed [ErrW-1:0] steps_x1;
  logic signed [ErrW-1:0] steps_x2;
  logic                   err_neg;
  logic                   at_last;

  // one quotient bit per cycle
  assign part = {rem_q, quo_q[RiseW-1]};
  assign diff = {1'b0, part} - {2'b00, steps_q};
  assign fits = !diff[StepW+1];

  assign inc_small = {2'b00, rem_q, 1'b0};
  assign steps_x1  = {3'b000, steps_q};
  assign steps_x2  = {2'b00, steps_q, 1'b0};
  assign err_neg   = err_q[ErrW-1];
  assign at_last   = (cnt_q == steps_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      steps_q <= span_steps_i;
      rem_q   <= '0;
      quo_q   <= rise_i;
      val_q   <= start_value_i;
      cnt_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= fits ? diff[StepW-1:0] : part[StepW-1:0];
      quo_q <= {quo_q[RiseW-2:0], fits};
    end
    if (cmd_i.init_err) begin
      err_q <= inc_small - steps_x1;
    end
    if (cmd_i.emit) begin
      val_q <= val_q + {{(ValW-RiseW){1'b0}}, quo_q} + {{(ValW-1){1'b0}}, !err_neg};
      err_q <= err_neg ? (err_q + inc_small) : (err_q + inc_small - steps_x2);
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign stat_o.steps_zero = (span_steps_i == '0);
  assign stat_o.at_last    = at_last;
  assign sample_o          = val_q;
  assign last_o            = at_last;

endmodule

>>> rtl/integer_linear_interp_span.sv
// Top level: Bresenham-style integer linear interpolation over one span.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-------------------------------------
//  request   | start_i, busy_o          | span_steps_i, rise_i, start_value_i
//  sample    | valid_o (per sample)     | sample_o, last_o
//
// Sequence: a request is taken when start_i is high and busy_o low. A zero step
// count gives its single sample in the next cycle. Otherwise the bit-serial
// divider produces one quotient bit per cycle over the 15-bit rise, the init
// state sets up the error term, then span_steps+1 samples follow on
// consecutive cycles. busy_o drops the cycle after the last sample; reset
// (async, low) returns to idle. The receiver cannot stall; samples stream out
// back to back.
module integer_linear_interp_span import ilis_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [StepW-1:0]       span_steps_i,
  input  logic [RiseW-1:0]       rise_i,
  input  logic signed [ValW-1:0] start_value_i,
  output logic                   valid_o,
  output logic signed [ValW-1:0] sample_o,
  output logic                   last_o
);

`include "assert_macros.svh"

  ilis_cmd_t  cmd;
  ilis_stat_t stat;

  // sequencing: idle -> divide -> init -> emit, or idle -> emit for zero steps
  ilis_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  // quotient/remainder, error term, running sample
  ilis_dp u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .span_steps_i (span_steps_i),
    .rise_i       (rise_i),
    .start_value_i(start_value_i),
    .stat_o       (stat),
    .sample_o     (sample_o),
    .last_o       (last_o)
  );

  // a sample goes out on every emit cycle
  assign valid_o = cmd.emit;

  `ILIS_ASSERT(a_valid_busy, valid_o |-> busy_o, "sample strobe while idle")
  `ILIS_ASSERT(a_req_busy, (start_i && !busy_o) |=> busy_o, "request taken but not busy")
  `ILIS_ASSERT(a_last_idle, (valid_o && last_o) |=> !busy_o, "still busy after last sample")
  `ILIS_ASSERT(a_stream, (valid_o && !last_o) |=> valid_o, "gap inside a span's samples")
  `ILIS_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !valid_o, "sample strobe during reset")

endmodule
